### design/cla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg: shared types and codes of the control lease arbiter
// Item, result and lease state structs, status codes and owner/mode codes.
// ----------------------------------------------------------------------------
package cla_pkg;

    typedef struct packed {
        logic        op;
        logic [1:0]  req_owner;
        logic [1:0]  req_mode;
        logic        take_lease;
        logic        force_take;
        logic [31:0] now_ms;
        logic        kvm_raw;
        logic        takeover;
        logic [31:0] kvm_left_ms;
    } cla_item_t;

    typedef struct packed {
        logic [1:0]  status_code;
        logic        agent_live;
        logic        actions_allowed;
        logic        owner_match;
        logic [31:0] lease_left_ms;
        logic [31:0] expiry_ms;
        logic [1:0]  shown_owner;
        logic [2:0]  shown_mode;
        logic        held_owner;
        logic        any_active;
        logic        request_open;
        logic        kvm_on;
    } cla_result_t;

    typedef struct packed {
        logic        seen;
        logic [31:0] renew_time;
        logic        owner;
        logic [1:0]  mode;
    } cla_lease_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_ARG     = 2'd1,
        STATUS_KVM_ACTIVE  = 2'd2,
        STATUS_HELD_OTHER  = 2'd3
    } cla_status_t;

    localparam logic        OP_QUERY  = 1'b0;
    localparam logic        OP_UPDATE = 1'b1;

    localparam logic        OWNER_AGENT = 1'b0;
    localparam logic        OWNER_MCP   = 1'b1;

    // Requested owner names as they arrive; the two top codes are not valid names.
    localparam logic [1:0]  REQ_OWNER_AGENT  = 2'd0;
    localparam logic [1:0]  REQ_OWNER_MCP    = 2'd1;
    localparam logic [1:0]  REQ_OWNER_BAD    = 2'd2;
    localparam logic [1:0]  REQ_OWNER_BAD_HI = 2'd3;

    localparam logic [1:0]  MODE_OBSERVE    = 2'd0;
    localparam logic [1:0]  MODE_SUPERVISED = 2'd1;
    localparam logic [1:0]  MODE_AUTONOMOUS = 2'd2;
    localparam logic [1:0]  MODE_INVALID    = 2'd3;

    localparam logic [1:0]  SHOWN_OWNER_NONE  = 2'd0;
    localparam logic [1:0]  SHOWN_OWNER_KVM   = 2'd1;
    localparam logic [1:0]  SHOWN_OWNER_AGENT = 2'd2;
    localparam logic [1:0]  SHOWN_OWNER_MCP   = 2'd3;

    localparam logic [2:0]  SHOWN_MODE_IDLE    = 3'd0;
    localparam logic [2:0]  SHOWN_MODE_MANUAL  = 3'd1;
    localparam logic [2:0]  SHOWN_MODE_OBSERVE = 3'd2;

    localparam logic [31:0] GRACE_RESET_MS = 32'd30000;

endpackage

### design/cla_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_eval: lease decision and status evaluation
// Validates one request against the stored lease, gives the next lease state
// and the status seen after the update at the request's own timestamp.
// ----------------------------------------------------------------------------
module cla_eval (
    input  cla_pkg::cla_item_t   item,
    input  cla_pkg::cla_lease_t  lease,
    input  logic [31:0]          grace_ms,
    output cla_pkg::cla_lease_t  lease_next,
    output cla_pkg::cla_result_t result
);

    logic        kvm;
    logic [31:0] elapsed;
    logic        act_before;
    logic        owner_ok;
    logic        mode_ok;
    logic        other_held;
    logic        take_ok;
    logic        release_ok;
    logic [1:0]  code;
    logic        act_after;
    logic [31:0] elapsed_after;
    logic [31:0] left;
    logic        agent;

    assign kvm        = item.kvm_raw & ~item.takeover;
    assign elapsed    = item.now_ms - lease.renew_time;
    assign act_before = lease.seen && (elapsed <= grace_ms);
    assign owner_ok   = (item.req_owner[1] == 1'b0);
    assign mode_ok    = (item.req_mode != cla_pkg::MODE_INVALID);
    assign other_held = act_before && (lease.owner != item.req_owner[0]);

    always_comb
    begin
        code       = cla_pkg::STATUS_OK;
        take_ok    = 1'b0;
        release_ok = 1'b0;
        if (item.op == cla_pkg::OP_UPDATE)
        begin
            if (!owner_ok || (item.take_lease && !mode_ok))
            begin
                code = cla_pkg::STATUS_BAD_ARG;
            end
            else if (item.take_lease && kvm)
            begin
                code = cla_pkg::STATUS_KVM_ACTIVE;
            end
            else if (item.take_lease && other_held && !item.force_take)
            begin
                code = cla_pkg::STATUS_HELD_OTHER;
            end
            else if (item.take_lease)
            begin
                take_ok = 1'b1;
            end
            else if (!act_before || (lease.owner == item.req_owner[0]) || item.force_take)
            begin
                // A release that is not entitled is silently ignored.
                release_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        lease_next = lease;
        if (take_ok)
        begin
            lease_next.seen       = 1'b1;
            lease_next.renew_time = item.now_ms;
            lease_next.owner      = item.req_owner[0];
            lease_next.mode       = item.req_mode;
        end
        else if (release_ok)
        begin
            lease_next.seen  = 1'b0;
            lease_next.owner = item.req_owner[0];
        end
    end

    // A fresh take is renewed at this very timestamp, so it is active with
    // no time elapsed; a release leaves the lease inactive.
    assign act_after     = take_ok | (~release_ok & act_before);
    assign elapsed_after = take_ok ? 32'd0 : elapsed;
    assign left          = act_after ? (grace_ms - elapsed_after) : 32'd0;
    assign agent         = act_after & ~kvm;

    always_comb
    begin
        result.status_code     = code;
        result.agent_live      = agent;
        result.actions_allowed = agent && (lease_next.mode != cla_pkg::MODE_OBSERVE);
        result.owner_match     = act_after && owner_ok
                                 && (lease_next.owner == item.req_owner[0]);
        result.lease_left_ms   = left;
        result.expiry_ms       = kvm ? item.kvm_left_ms : left;
        if (kvm)
        begin
            result.shown_owner = cla_pkg::SHOWN_OWNER_KVM;
            result.shown_mode  = cla_pkg::SHOWN_MODE_MANUAL;
        end
        else if (act_after)
        begin
            result.shown_owner = (lease_next.owner == cla_pkg::OWNER_MCP)
                                 ? cla_pkg::SHOWN_OWNER_MCP : cla_pkg::SHOWN_OWNER_AGENT;
            result.shown_mode  = cla_pkg::SHOWN_MODE_OBSERVE + {1'b0, lease_next.mode};
        end
        else
        begin
            result.shown_owner = cla_pkg::SHOWN_OWNER_NONE;
            result.shown_mode  = cla_pkg::SHOWN_MODE_IDLE;
        end
        result.held_owner   = lease_next.owner;
        result.any_active   = kvm | agent;
        result.request_open = ~kvm;
        result.kvm_on       = kvm;
    end

endmodule

### design/control_lease_arbiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_lease_arbiter_unit: control lease with grace timeout
//
//   Channel   Signals                              Direction   Carries
//   item      item_valid, item_ready, item         in          one request
//   result    result_valid, result_ready, result   out         one status
//   cfg       cfg_valid, cfg_ready, cfg_data       in          grace_ms
//
// A request is registered on transfer, evaluated against the lease once the
// result register is free, and its status lands in the result register:
// one request per cycle sustained while statuses are accepted, set by the
// single evaluation stage. The lease updates as the status is captured, so
// consecutive requests see each other's effect. Reset clears the lease and
// sets grace_ms to 30000. A stalled result holds the stage behind it while
// one more request can still be taken into the input register.
// ----------------------------------------------------------------------------
module control_lease_arbiter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  cla_pkg::cla_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output cla_pkg::cla_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    cla_pkg::cla_item_t   item_reg;
    logic                 item_valid_reg;
    cla_pkg::cla_result_t result_reg;
    logic                 result_valid_reg;
    cla_pkg::cla_lease_t  lease_reg;
    cla_pkg::cla_lease_t  lease_next;
    cla_pkg::cla_result_t result_next;
    logic [31:0]          grace_reg;
    logic                 advance;

    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    cla_eval u_eval (
        .item       (item_reg),
        .lease      (lease_reg),
        .grace_ms   (grace_reg),
        .lease_next (lease_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            grace_reg        <= cla_pkg::GRACE_RESET_MS;
            lease_reg.seen       <= 1'b0;
            lease_reg.renew_time <= 32'd0;
            lease_reg.owner      <= cla_pkg::OWNER_AGENT;
            lease_reg.mode       <= cla_pkg::MODE_SUPERVISED;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                lease_reg        <= lease_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                grace_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### dv/cla_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_status_checker: status prediction and comparison for the lease arbiter
// Watches the request, status and grace register channels. Every request
// transfer is run through a local model of the lease and its predicted
// status is queued; every status transfer is compared with the oldest
// queued prediction.
// ----------------------------------------------------------------------------
module cla_status_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  cla_pkg::cla_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  cla_pkg::cla_result_t result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    output int                   mismatches,
    output int                   pending
);

    localparam logic [2:0] SHOWN_MODE_AUTONOMOUS = 3'd4;

    cla_pkg::cla_lease_t  lease;
    logic [31:0]          grace_ms;
    cla_pkg::cla_result_t status_q[$];
    cla_pkg::cla_result_t want;
    int                   error_count = 0;

    assign mismatches = error_count;

    function automatic logic lease_live(logic [31:0] now_ms);
        logic [31:0] elapsed;
        elapsed = now_ms - lease.renew_time;
        return lease.seen && (elapsed <= grace_ms);
    endfunction

    // Applies one request to the local lease and returns the status it yields.
    function automatic cla_pkg::cla_result_t predict_status(cla_pkg::cla_item_t req);
        cla_pkg::cla_result_t st;
        logic                 kvm;
        logic                 owner_ok;
        logic                 act;
        logic                 agent;
        logic [31:0]          left;
        logic [2:0]           smode;
        cla_pkg::cla_status_t code;
        kvm      = req.kvm_raw && !req.takeover;
        owner_ok = (req.req_owner <= cla_pkg::REQ_OWNER_MCP);
        code     = cla_pkg::STATUS_OK;
        if (req.op == cla_pkg::OP_UPDATE)
        begin
            if (!owner_ok || (req.take_lease && req.req_mode == cla_pkg::MODE_INVALID))
            begin
                code = cla_pkg::STATUS_BAD_ARG;
            end
            else if (req.take_lease && kvm)
            begin
                code = cla_pkg::STATUS_KVM_ACTIVE;
            end
            else if (req.take_lease && lease_live(req.now_ms)
                     && lease.owner != req.req_owner[0] && !req.force_take)
            begin
                code = cla_pkg::STATUS_HELD_OTHER;
            end
            else if (req.take_lease)
            begin
                lease.seen       = 1'b1;
                lease.renew_time = req.now_ms;
                lease.owner      = req.req_owner[0];
                lease.mode       = req.req_mode;
            end
            else if (!lease_live(req.now_ms) || lease.owner == req.req_owner[0]
                     || req.force_take)
            begin
                // An entitled release; any other release leaves everything as it was.
                lease.seen  = 1'b0;
                lease.owner = req.req_owner[0];
            end
        end

        act   = lease_live(req.now_ms);
        agent = act && !kvm;
        left  = act ? grace_ms - (req.now_ms - lease.renew_time) : 32'd0;
        smode = cla_pkg::SHOWN_MODE_OBSERVE + {1'b0, lease.mode};
        if (smode > SHOWN_MODE_AUTONOMOUS)
            smode = SHOWN_MODE_AUTONOMOUS;

        st.status_code     = code;
        st.agent_live      = agent;
        st.actions_allowed = agent && (lease.mode != cla_pkg::MODE_OBSERVE);
        st.owner_match     = act && owner_ok && (lease.owner == req.req_owner[0]);
        st.lease_left_ms   = left;
        st.expiry_ms       = kvm ? req.kvm_left_ms : left;
        if (kvm)
            st.shown_owner = cla_pkg::SHOWN_OWNER_KVM;
        else if (!act)
            st.shown_owner = cla_pkg::SHOWN_OWNER_NONE;
        else if (lease.owner == cla_pkg::OWNER_MCP)
            st.shown_owner = cla_pkg::SHOWN_OWNER_MCP;
        else
            st.shown_owner = cla_pkg::SHOWN_OWNER_AGENT;
        st.shown_mode   = kvm ? cla_pkg::SHOWN_MODE_MANUAL
                              : (act ? smode : cla_pkg::SHOWN_MODE_IDLE);
        st.held_owner   = lease.owner;
        st.any_active   = kvm || agent;
        st.request_open = !kvm;
        st.kvm_on       = kvm;
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] status mismatch: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease    = '{seen: 1'b0, renew_time: 32'd0, owner: cla_pkg::OWNER_AGENT,
                         mode: cla_pkg::MODE_SUPERVISED};
            grace_ms = cla_pkg::GRACE_RESET_MS;
            status_q.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (status_q.size() == 0)
                begin
                    report_mismatch("status transfer with no request outstanding");
                end
                else
                begin
                    want = status_q.pop_front();
                    if (result !== want)
                        report_mismatch($sformatf("got %p, predicted %p", result, want));
                end
            end
            if (cfg_valid && cfg_ready)
                grace_ms = cfg_data;
            if (item_valid && item_ready)
                status_q.push_back(predict_status(item));
            pending <= status_q.size();
        end
    end

endmodule

### dv/control_lease_arbiter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_lease_arbiter_unit_test: stimulus and verdict for the lease arbiter
// A directed run over the lease rules is followed by random request streams
// under several grace times, from zero to the full 32-bit range, with
// random idling on both sides and a long status back-pressure burst.
// ----------------------------------------------------------------------------
module control_lease_arbiter_unit_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 122;
    localparam int NUM_PHASES = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    cla_pkg::cla_item_t   item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    cla_pkg::cla_result_t result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [31:0]          cfg_data = '0;

    int          mismatches;
    int          pending;
    int          send_idle = 37;
    int          recv_idle = 82;
    int          hold_len = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;
    logic [31:0] last_take_ms = '0;
    logic [31:0] cur_grace = cla_pkg::GRACE_RESET_MS;

    control_lease_arbiter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    cla_status_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    function automatic cla_pkg::cla_item_t make_item(logic f_op, logic [1:0] f_owner,
                                                     logic [1:0] f_mode, logic f_take,
                                                     logic f_force, logic [31:0] f_now,
                                                     logic f_kraw, logic f_tko,
                                                     logic [31:0] f_kleft);
        cla_pkg::cla_item_t it;
        it.op          = f_op;
        it.req_owner   = f_owner;
        it.req_mode    = f_mode;
        it.take_lease  = f_take;
        it.force_take  = f_force;
        it.now_ms      = f_now;
        it.kvm_raw     = f_kraw;
        it.takeover    = f_tko;
        it.kvm_left_ms = f_kleft;
        return it;
    endfunction

    // Valid is only lowered for a gap, so back-to-back requests keep it high.
    task automatic send_item(input cla_pkg::cla_item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic drain_statuses();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_grace(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_grace  = value;
    endtask

    // Status side: random stalls, plus an occasional long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            result_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(item_valid && item_ready) && !(result_valid && result_ready)
            && !(cfg_valid && cfg_ready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cla_pkg::cla_item_t it;
        int                 roll;
        int                 span;
        logic [31:0]        grace_plan [NUM_PHASES];

        grace_plan = '{cla_pkg::GRACE_RESET_MS, 32'd0, 32'd500, 32'hFFFF_FFFF,
                       32'($urandom_range(1000, 200000)), 32'd1};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass under the grace time left by reset.
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'd0,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_SUPERVISED, 1'b1, 1'b0, 32'd100,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'd30100,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'd30101,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_SUPERVISED, 1'b1, 1'b0, 32'd30200,
                            1'b0, 1'b0, 32'd0));
        // Another owner's live lease: refused, then forced.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_AUTONOMOUS, 1'b1, 1'b0, 32'd30300,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_AUTONOMOUS, 1'b1, 1'b1, 32'd30400,
                            1'b0, 1'b0, 32'd0));
        // Bad owner names and a bad mode on a take.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_BAD,
                            cla_pkg::MODE_SUPERVISED, 1'b1, 1'b0, 32'd30500,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_BAD_HI,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'd30500,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_INVALID, 1'b1, 1'b0, 32'd30600,
                            1'b0, 1'b0, 32'd0));
        // A release pays no attention to the mode.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_INVALID, 1'b0, 1'b0, 32'd30700,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_OBSERVE, 1'b1, 1'b0, 32'd30800,
                            1'b0, 1'b0, 32'd0));
        // Manual KVM: a take is refused, a release still goes through.
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_OBSERVE, 1'b0, 1'b0, 32'd30900,
                            1'b1, 1'b0, 32'hFFFF_FFFF));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_OBSERVE, 1'b1, 1'b0, 32'd31000,
                            1'b1, 1'b0, 32'd1234));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_OBSERVE, 1'b0, 1'b0, 32'd31100,
                            1'b1, 1'b0, 32'd0));
        // Takeover cancels the KVM claim.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_AUTONOMOUS, 1'b1, 1'b0, 32'd31200,
                            1'b1, 1'b1, 32'd77));
        // Release by the other owner: ignored unless forced.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_OBSERVE, 1'b0, 1'b0, 32'd31300,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_OBSERVE, 1'b0, 1'b1, 32'd31400,
                            1'b0, 1'b0, 32'd0));
        // A renewal just before the counter wraps, checked just after it.
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_SUPERVISED, 1'b1, 1'b0, 32'hFFFF_FFF0,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_MCP,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'h0000_0010,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_BAD,
                            cla_pkg::MODE_SUPERVISED, 1'b0, 1'b0, 32'h0000_0020,
                            1'b0, 1'b0, 32'd0));
        send_item(make_item(cla_pkg::OP_UPDATE, cla_pkg::REQ_OWNER_BAD_HI,
                            cla_pkg::MODE_INVALID, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(make_item(cla_pkg::OP_QUERY, cla_pkg::REQ_OWNER_AGENT,
                            cla_pkg::MODE_OBSERVE, 1'b0, 1'b0, 32'd0,
                            1'b0, 1'b0, 32'd0));
        drain_statuses();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle = 37;
                recv_idle = 82;
            end
            else if (phase < 4)
            begin
                send_idle = 82;
                recv_idle = 37;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_grace(grace_plan[phase]);
            span = (cur_grace > 32'd50000) ? 50000 : int'(cur_grace) + 1;

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Long status hold-off while requests keep coming.
                if (phase == 0 && n == 40)
                    hold_len = 80;

                roll = $urandom_range(0, 99);
                if (roll < 35)
                    clock_ms += $urandom_range(0, 20);
                else if (roll < 65)
                    clock_ms += $urandom_range(0, 2 * span);
                else if (roll < 75)
                    clock_ms = last_take_ms + cur_grace + $urandom_range(0, 1);
                else if (roll < 85)
                    clock_ms = $urandom;
                else if (roll < 92)
                    clock_ms -= $urandom_range(1, 50);

                it.op = ($urandom_range(0, 99) < 75) ? cla_pkg::OP_UPDATE
                                                     : cla_pkg::OP_QUERY;
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    it.req_owner = cla_pkg::REQ_OWNER_AGENT;
                else if (roll < 90)
                    it.req_owner = cla_pkg::REQ_OWNER_MCP;
                else
                    it.req_owner = ($urandom_range(0, 1) != 0) ? cla_pkg::REQ_OWNER_BAD
                                                               : cla_pkg::REQ_OWNER_BAD_HI;
                it.req_mode = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 2))
                                                           : cla_pkg::MODE_INVALID;
                it.take_lease  = ($urandom_range(0, 99) < 70);
                it.force_take  = ($urandom_range(0, 99) < 20);
                it.now_ms      = clock_ms;
                it.kvm_raw     = ($urandom_range(0, 99) < 20);
                it.takeover    = 1'($urandom_range(0, 1));
                it.kvm_left_ms = $urandom;
                if (it.op == cla_pkg::OP_UPDATE && it.take_lease)
                    last_take_ms = clock_ms;
                send_item(it);
            end
            drain_statuses();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
